### hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial accumulator.
// No dependencies; imported by every module in hdl.
package spa_pkg;

  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 32;
  localparam int EXPI_W    = 15;
  localparam int EXPO_W    = 16;

  typedef enum logic [1:0] {
    MODE_TERM = 2'd0,
    MODE_PROD = 2'd1,
    MODE_DUMP = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SRD,
    S_SCMP,
    S_SHR_RD,
    S_SHR_WR,
    S_SHL_RD,
    S_SHL_WR,
    S_DRD,
    S_DOUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [EXPO_W-1:0] expo;
    logic [COEF_W-1:0] coef;
  } tbl_wr_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic sum_zero;
  } cmp_t;

endpackage

### hdl/spa_table.sv
// Term table: one write port, one read port with registered read data.
// Depends on spa_pkg.
module spa_table (
  input  logic                      clk,
  input  spa_pkg::tbl_wr_t          wr,
  input  logic [spa_pkg::IDX_W-1:0] raddr,
  output logic [spa_pkg::EXPO_W-1:0] rd_expo,
  output logic [spa_pkg::COEF_W-1:0] rd_coef
);
  import spa_pkg::*;

  logic [EXPO_W-1:0] expos [MAX_TERMS];
  logic [COEF_W-1:0] coefs [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      expos[wr.addr] <= wr.expo;
      coefs[wr.addr] <= wr.coef;
    end
  end

  always_ff @(posedge clk) begin
    rd_expo <= expos[raddr];
    rd_coef <= coefs[raddr];
  end

endmodule

### hdl/spa_unit.sv
// Shared arithmetic unit: registered term (product or direct), exponent
// compare and coefficient merge add. Depends on spa_pkg.
module spa_unit (
  input  logic                       clk,
  input  logic                       ld,
  input  logic                       prod_sel,
  input  logic signed [spa_pkg::COEF_W-1:0] coef,
  input  logic [spa_pkg::EXPI_W-1:0] expo,
  input  logic signed [spa_pkg::COEF_W-1:0] coef_b,
  input  logic [spa_pkg::EXPI_W-1:0] expo_b,
  input  logic [spa_pkg::EXPO_W-1:0] rd_expo,
  input  logic [spa_pkg::COEF_W-1:0] rd_coef,
  output logic [spa_pkg::EXPO_W-1:0] term_expo,
  output logic [spa_pkg::COEF_W-1:0] term_coef,
  output logic                       term_zero,
  output logic [spa_pkg::COEF_W-1:0] sum,
  output spa_pkg::cmp_t              cmp
);
  import spa_pkg::*;

  logic [COEF_W-1:0] prod;
  logic [EXPO_W-1:0] esum;

  assign prod = COEF_W'(coef * coef_b);
  assign esum = EXPO_W'(expo) + EXPO_W'(expo_b);

  always_ff @(posedge clk) begin
    if (ld) begin
      term_coef <= prod_sel ? prod : COEF_W'(coef);
      term_expo <= prod_sel ? esum : EXPO_W'(expo);
    end
  end

  assign term_zero    = (term_coef == '0);
  assign sum          = rd_coef + term_coef;
  assign cmp.gt       = (rd_expo > term_expo);
  assign cmp.eq       = (rd_expo == term_expo);
  assign cmp.sum_zero = (sum == '0);

endmodule

### hdl/sparse_polynomial_accumulator.sv
// Top level: sequencer, term count and result register of the accumulator.
// Depends on spa_pkg, spa_table and spa_unit.
//
//  channel | handshake          | fields
//  --------+--------------------+----------------------------------------------
//  command | start / busy       | mode, coef, expo, coef_b, expo_b
//  result  | strobe, one cycle  | out_coef, out_expo, last, empty_res, status
//
// Insert: check state, read and compare per entry compared, a read on reaching
// the end of the table, read and write per entry moved, a read to place a new
// term or close a removal, then the result beat. The single table read port sets
// the pace. Dump: check, read and output per term. Unused mode, zero term: check.
// Reset clears the sequencer and term count; the table itself needs no clear.
// An insert beat and the last dump beat coincide with the fall of busy; no stall.
module sparse_polynomial_accumulator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic signed [31:0]         coef,
  input  logic [14:0]                expo,
  input  logic signed [31:0]         coef_b,
  input  logic [14:0]                expo_b,
  output logic                       strobe,
  output logic signed [31:0]         out_coef,
  output logic [15:0]                out_expo,
  output logic                       last,
  output logic                       empty_res,
  output logic                       status
);
  import spa_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

  state_t            state, state_next;
  logic [1:0]        mode_q, mode_q_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  j, j_next;
  logic [CNT_W-1:0]  count, count_next;

  logic              accept;
  tbl_wr_t           wr;
  logic [CNT_W-1:0]  raddr_w;
  logic [EXPO_W-1:0] rd_expo, term_expo;
  logic [COEF_W-1:0] rd_coef, term_coef, sum;
  logic              term_zero;
  cmp_t              cmp;

  logic              emit, emit_last, emit_empty, emit_status;
  logic [COEF_W-1:0] emit_coef;
  logic [EXPO_W-1:0] emit_expo;
  logic [CNT_W-1:0]  j_dec, j_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign j_dec  = j - 1'b1;
  assign j_inc  = j + 1'b1;

  spa_table u_table (
    .clk     (clk),
    .wr      (wr),
    .raddr   (raddr_w[IDX_W-1:0]),
    .rd_expo (rd_expo),
    .rd_coef (rd_coef)
  );

  spa_unit u_unit (
    .clk       (clk),
    .ld        (accept),
    .prod_sel  (mode == MODE_PROD),
    .coef      (coef),
    .expo      (expo),
    .coef_b    (coef_b),
    .expo_b    (expo_b),
    .rd_expo   (rd_expo),
    .rd_coef   (rd_coef),
    .term_expo (term_expo),
    .term_coef (term_coef),
    .term_zero (term_zero),
    .sum       (sum),
    .cmp       (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    mode_q    <= mode_q_next;
    pos       <= pos_next;
    j         <= j_next;
    out_coef  <= emit_coef;
    out_expo  <= emit_expo;
    last      <= emit_last;
    empty_res <= emit_empty;
    status    <= emit_status;
  end

  always_comb begin
    state_next  = state;
    mode_q_next = mode_q;
    pos_next    = pos;
    j_next      = j;
    count_next  = count;
    raddr_w     = '0;
    wr          = '0;
    emit        = 1'b0;
    emit_coef   = '0;
    emit_expo   = '0;
    emit_last   = 1'b1;
    emit_empty  = 1'b0;
    emit_status = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q_next = mode;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        case (mode_q)
          MODE_TERM, MODE_PROD: begin
            if (term_zero) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end else begin
              pos_next   = '0;
              state_next = S_SRD;
            end
          end
          MODE_DUMP: begin
            if (count == '0) begin
              emit       = 1'b1;
              emit_empty = 1'b1;
              state_next = S_IDLE;
            end else begin
              j_next     = '0;
              state_next = S_DRD;
            end
          end
          default: begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SRD: begin
        raddr_w = pos;
        if (pos == count) begin
          if (count == MAX_CNT) begin
            emit        = 1'b1;
            emit_status = 1'b1;
            state_next  = S_IDLE;
          end else begin
            j_next     = count;
            state_next = S_SHR_RD;
          end
        end else begin
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (cmp.gt) begin
          pos_next   = pos + 1'b1;
          state_next = S_SRD;
        end else if (cmp.eq) begin
          if (cmp.sum_zero) begin
            j_next     = pos;
            state_next = S_SHL_RD;
          end else begin
            wr.en      = 1'b1;
            wr.addr    = pos[IDX_W-1:0];
            wr.expo    = term_expo;
            wr.coef    = sum;
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (count == MAX_CNT) begin
          emit        = 1'b1;
          emit_status = 1'b1;
          state_next  = S_IDLE;
        end else begin
          j_next     = count;
          state_next = S_SHR_RD;
        end
      end
      S_SHR_RD: begin
        raddr_w = j_dec;
        if (j == pos) begin
          wr.en      = 1'b1;
          wr.addr    = pos[IDX_W-1:0];
          wr.expo    = term_expo;
          wr.coef    = term_coef;
          count_next = count + 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SHR_WR;
        end
      end
      S_SHR_WR: begin
        wr.en      = 1'b1;
        wr.addr    = j[IDX_W-1:0];
        wr.expo    = rd_expo;
        wr.coef    = rd_coef;
        j_next     = j_dec;
        state_next = S_SHR_RD;
      end
      S_SHL_RD: begin
        raddr_w = j_inc;
        if (j_inc == count) begin
          count_next = count - 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SHL_WR;
        end
      end
      S_SHL_WR: begin
        wr.en      = 1'b1;
        wr.addr    = j[IDX_W-1:0];
        wr.expo    = rd_expo;
        wr.coef    = rd_coef;
        j_next     = j_inc;
        state_next = S_SHL_RD;
      end
      S_DRD: begin
        raddr_w    = j;
        state_next = S_DOUT;
      end
      S_DOUT: begin
        emit      = 1'b1;
        emit_coef = rd_coef;
        emit_expo = rd_expo;
        emit_last = (j_inc == count);
        if (j_inc == count) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          j_next     = j_inc;
          state_next = S_DRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("term count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> count == MAX_CNT)
    else $error("full status with room in the table");

  a_mid_dump: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> !status && !empty_res && busy)
    else $error("non-final beat outside a dump");
`endif

endmodule
